/* src/lexc_pkg.sv */
// Shared types, constants and helper functions for the lexical token classifier.
`default_nettype none

package lexc_pkg;

  localparam int WORD_BUFFER = 20;
  localparam int COUNT_WIDTH = 16;
  localparam int WORD_MAX    = WORD_BUFFER - 1;
  localparam int LEN_W       = $clog2(WORD_MAX + 1);
  localparam int IDX_W       = $clog2(WORD_MAX);
  localparam int NUM_KW      = 27;
  localparam int KW_SLOTS    = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [2:0] {
    KIND_OPERATOR = 3'd0,
    KIND_SYMBOL   = 3'd1,
    KIND_DIGIT    = 3'd2,
    KIND_KEYWORD  = 3'd3,
    KIND_IDENT    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_START   = 3'd2,
    ACT_SINGLE  = 3'd3,
    ACT_NEWLINE = 3'd4,
    ACT_RESTART = 3'd5
  } act_t;

  // one queued command: optional word flush, then an action
  typedef struct packed {
    logic       flush;
    act_t       act;
    kind_t      kind;
    logic [7:0] ch;
  } cmd_t;

  // keyword text, right-justified (first character in the highest used byte)
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("int"), 64'("main"), 64'("if"), 64'("else"), 64'("do"), 64'("while"),
    64'("include"), 64'("stdio"), 64'("malloc"), 64'("for"), 64'("printf"),
    64'("scanf"), 64'("ctype"), 64'("stdlib"), 64'("string"), 64'("math"),
    64'("void"), 64'("char"), 64'("getchar"), 64'("type"), 64'("isalpha"),
    64'("toascii"), 64'("switch"), 64'("case"), 64'("break"), 64'("exit"),
    64'("return")
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd4, 4'd2, 4'd4, 4'd2, 4'd5, 4'd7, 4'd5, 4'd6, 4'd3, 4'd6,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4, 4'd7, 4'd4, 4'd7, 4'd7,
    4'd6, 4'd4, 4'd5, 4'd4, 4'd6
  };

  // character p of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
    logic [7:0] r;
    int         sh;
    r  = 8'd0;
    sh = (int'(KW_LEN[k]) - 1 - int'(p)) * 8;
    if (int'(p) < int'(KW_LEN[k])) begin
      r = KW_TEXT[k][sh +: 8];
    end
    return r;
  endfunction

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == ";" || c == "{" || c == "}" || c == "(" || c == ")" ||
           c == "?" || c == "@" || c == "!" || c == "%";
  endfunction

endpackage

`default_nettype wire

/* src/lexc_front.sv */
// Front end: accepts text bytes, classifies them and queues commands.
`default_nettype none

module lexc_front
  import lexc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_input,
  input  wire logic       fifo_full,
  output logic            push,
  output cmd_t            push_cmd
);

  logic in_word;
  logic in_word_next;
  logic accept;

  assign byte_stall = fifo_full;
  assign accept     = byte_valid && !fifo_full;

  always_comb begin
    push_cmd.flush = 1'b0;
    push_cmd.act   = ACT_NONE;
    push_cmd.kind  = KIND_OPERATOR;
    push_cmd.ch    = char_code;
    in_word_next   = 1'b0;
    priority if (end_of_input) begin
      push_cmd.flush = 1'b1;
      push_cmd.act   = ACT_RESTART;
    end else if (in_word && (is_letter(char_code) || is_digit(char_code))) begin
      push_cmd.act = ACT_APPEND;
      in_word_next = 1'b1;
    end else begin
      // anything else ends a pending word, then is handled on its own
      push_cmd.flush = in_word;
      priority if (char_code == 8'h0A) begin
        push_cmd.act = ACT_NEWLINE;
      end else if (is_operator(char_code)) begin
        push_cmd.act = ACT_SINGLE;
      end else if (is_symbol(char_code)) begin
        push_cmd.act  = ACT_SINGLE;
        push_cmd.kind = KIND_SYMBOL;
      end else if (is_digit(char_code)) begin
        push_cmd.act  = ACT_SINGLE;
        push_cmd.kind = KIND_DIGIT;
      end else if (is_letter(char_code)) begin
        push_cmd.act = ACT_START;
        in_word_next = 1'b1;
      end else begin
        push_cmd.act = ACT_NONE;
      end
    end
  end

  // ignored bytes outside a word need no command
  assign push = accept && (push_cmd.flush || push_cmd.act != ACT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word <= 1'b0;
    end else if (accept) begin
      in_word <= in_word_next;
    end
  end

endmodule

`default_nettype wire

/* src/lexc_cmd_fifo.sv */
// Short command queue between the front end and the back end.
`default_nettype none

module lexc_cmd_fifo
  import lexc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full       = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* src/lexc_back.sv */
// Back end: word buffer, keyword match, counters and the output register.
`default_nettype none

module lexc_back
  import lexc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            pop,
  output logic            token_valid,
  input  wire logic       token_stall,
  output count_t          line_number,
  output count_t          token_index,
  output logic [2:0]      token_kind,
  output logic [7:0]      char_value,
  output logic            last_char,
  output logic            truncated
);

  typedef enum logic [1:0] {
    S_CMD  = 2'b01,
    S_WORD = 2'b10
  } state_t;

  state_t           state;
  count_t           line_count;
  count_t           token_count;
  logic [7:0]       word_chars [WORD_MAX];
  logic [LEN_W-1:0] word_length;
  logic             word_overflow;
  logic [NUM_KW-1:0] cand;
  logic [NUM_KW-1:0] cand_next;
  logic [IDX_W-1:0] rd_idx;
  logic             can_emit;
  logic             word_go;
  logic             word_last;
  logic             is_kw;
  kind_t            out_kind;

  assign can_emit  = !token_valid || !token_stall;
  assign word_go   = (state == S_CMD) && cmd_valid && cmd.flush && (word_length != '0);
  assign word_last = (LEN_W'(rd_idx) == word_length - LEN_W'(1));
  assign pop       = (state == S_CMD) && cmd_valid && !word_go &&
                     ((cmd.act != ACT_SINGLE) || can_emit);
  assign token_kind = out_kind;

  // keyword if every stored char matched and the length agrees
  always_comb begin
    is_kw = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && (LEN_W'(KW_LEN[k]) == word_length)) begin
        is_kw = 1'b1;
      end
    end
    is_kw = is_kw && !word_overflow;
  end

  // candidate mask after adding cmd.ch at the current length
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      if (cmd.act == ACT_START) begin
        cand_next[k] = (kw_char(k, 3'd0) == cmd.ch);
      end else if (32'(word_length) < KW_SLOTS) begin
        cand_next[k] = cand[k] && (kw_char(k, word_length[2:0]) == cmd.ch);
      end else begin
        cand_next[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CMD;
      line_count    <= count_t'(1);
      token_count   <= '0;
      word_length   <= '0;
      word_overflow <= 1'b0;
      rd_idx        <= '0;
      token_valid   <= 1'b0;
    end else begin
      if (token_valid && !token_stall) begin
        token_valid <= 1'b0;
      end
      unique case (state)
        S_CMD: begin
          if (word_go) begin
            state  <= S_WORD;
            rd_idx <= '0;
          end else if (pop) begin
            unique case (cmd.act)
              ACT_APPEND: begin
                if (32'(word_length) < WORD_MAX) begin
                  word_length <= word_length + LEN_W'(1);
                end else begin
                  word_overflow <= 1'b1;
                end
              end
              ACT_START: begin
                word_length   <= LEN_W'(1);
                word_overflow <= 1'b0;
              end
              ACT_SINGLE: begin
                token_valid <= 1'b1;
                token_count <= sat_inc(token_count);
              end
              ACT_NEWLINE: line_count <= sat_inc(line_count);
              ACT_RESTART: begin
                line_count  <= count_t'(1);
                token_count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_WORD: begin
          if (can_emit) begin
            token_valid <= 1'b1;
            rd_idx      <= rd_idx + IDX_W'(1);
            if (word_last) begin
              state         <= S_CMD;
              token_count   <= sat_inc(token_count);
              word_length   <= '0;
              word_overflow <= 1'b0;
            end
          end
        end
        default: state <= S_CMD;
      endcase
    end
  end

  // payload: word buffer, candidate mask, output fields
  always_ff @(posedge clk) begin
    if (pop && (cmd.act == ACT_START || cmd.act == ACT_APPEND)) begin
      cand <= cand_next;
      if (32'(word_length) < WORD_MAX || cmd.act == ACT_START) begin
        word_chars[(cmd.act == ACT_START) ? '0 : word_length[IDX_W-1:0]] <= cmd.ch;
      end
    end
    if (pop && cmd.act == ACT_SINGLE) begin
      line_number <= line_count;
      token_index <= token_count;
      out_kind    <= cmd.kind;
      char_value  <= cmd.ch;
      last_char   <= 1'b1;
      truncated   <= 1'b0;
    end else if (state == S_WORD && can_emit) begin
      line_number <= line_count;
      token_index <= token_count;
      out_kind    <= is_kw ? KIND_KEYWORD : KIND_IDENT;
      char_value  <= word_chars[rd_idx];
      last_char   <= word_last;
      truncated   <= word_overflow;
    end
  end

endmodule

`default_nettype wire

/* src/lexical_token_classifier_top.sv */
// Top level of the lexical token classifier: front end, command queue, back end.
//
// Input channel (byte_valid/byte_stall): one text byte per word in char_code,
// or an end marker in end_of_input that flushes a pending word and restarts
// both counters. Output channel (token_valid/token_stall): one word per
// emitted character with its line, token number, kind, last and cut flags.
// The front end classifies a byte in the cycle it is taken and queues at most
// one command; a byte is taken every cycle while the four-entry queue has room.
// The back end runs one command a cycle unless it is emitting a word or a
// stall at the output holds a single-character command; a word ending first
// starts the word, then emits its stored characters (at most 19) one at a
// time through the single read port of the word buffer. A single-character
// byte passes the queue and the output register before its result is valid.
// Reset (rst, synchronous): line counter 1, token counter 0, no word pending,
// queue empty, no result valid. A stall at the output holds the result
// register; the back end waits, the queue fills and then byte_stall rises.
`default_nettype none

module lexical_token_classifier_top
  import lexc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_input,
  output logic            token_valid,
  input  wire logic       token_stall,
  output count_t          line_number,
  output count_t          token_index,
  output logic [2:0]      token_kind,
  output logic [7:0]      char_value,
  output logic            last_char,
  output logic            truncated
);

  logic fifo_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // byte classification
  lexc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // decoupling queue
  lexc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // word buffer, keyword match, counters, output register
  lexc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .line_number (line_number),
    .token_index (token_index),
    .token_kind  (token_kind),
    .char_value  (char_value),
    .last_char   (last_char),
    .truncated   (truncated)
  );

endmodule

`default_nettype wire
